FILE: rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and types for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 32;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W       = 16;
    localparam int ENT_W        = 2 * ADDR_W + 1;
    localparam logic [15:0] ARENA_RESET = 16'd4096;
    localparam logic [15:0] HDR16       = 16'(HEADER_BYTES);

    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_FAILED   = 2'd1;
    localparam logic [1:0] ST_FREED    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [0:0] REG_ARENA = 1'b0;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] length;
        logic              used;
    } t_entry;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_START,
        OP_RD_CUR,
        OP_LATCH_CUR,
        OP_WR_ALLOC,
        OP_SH_UP,
        OP_WR_SPLIT,
        OP_FREE_CUR,
        OP_RD_NEXT,
        OP_MERGE_NEXT,
        OP_SH_DOWN,
        OP_RD_PREV,
        OP_MERGE_PREV,
        OP_STEP
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic hit;        // current entry matches request
        logic split_ok;   // split allowed
        logic last;       // index is the last entry of the table
        logic nbr_free;   // latched neighbor is free
        logic sh_done;    // shift pointer reached its stop
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] sh_ptr;
    } t_stat;
endpackage

FILE: rtl/ffba_if.sv
// ----------------------------------------------------------------------------
// ffba_req_if / ffba_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] request_size;
    logic [15:0] block_address;
    modport source (output valid, kind, request_size, block_address, input ready);
    modport sink (input valid, kind, request_size, block_address, output ready);
endinterface

interface ffba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] data_address;
    modport source (output valid, status, data_address, input ready);
    modport sink (input valid, status, data_address, output ready);
endinterface

FILE: rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/ffba_datapath.sv
// ----------------------------------------------------------------------------
// ffba_datapath
// Block table memory, working registers and arithmetic of the allocator.
// ----------------------------------------------------------------------------
module ffba_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffba_pkg::t_cmd        i_cmd,
    input  logic                  i_kind,
    input  logic [15:0]           i_size,
    input  logic [15:0]           i_addr,
    input  logic [15:0]           i_arena,
    output ffba_pkg::t_stat       o_stat,
    output logic [15:0]           o_data_address
);
    import ffba_pkg::*;

    logic             r_kind;
    logic [15:0]      r_size;
    logic [15:0]      r_addr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_sh, n_sh;
    t_entry           r_cur, n_cur;
    t_entry           r_nbr, n_nbr;
    logic [15:0]      r_dout, n_dout;

    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    t_entry           ram_wdata, ram_rdata;

    ffba_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    logic [15:0] rest;
    logic [15:0] arena_len;
    assign rest      = r_cur.length - r_size;
    assign arena_len = (i_arena >= HDR16) ? (i_arena - HDR16) : 16'd0;

    always_comb begin
        n_count  = r_count;
        n_idx    = r_idx;
        n_sh     = r_sh;
        n_cur    = r_cur;
        n_nbr    = r_nbr;
        n_dout   = r_dout;
        ram_we   = 1'b0;
        ram_addr = i_cmd.addr;
        ram_wdata = r_cur;
        case (i_cmd.op)
            OP_INIT: begin
                ram_we    = 1'b1;
                ram_addr  = '0;
                ram_wdata = '{offset: 16'd0, length: arena_len, used: 1'b0};
                n_count   = CNT_W'(1);
            end
            OP_START: begin
                n_idx  = '0;
                n_dout = 16'd0;
            end
            OP_LATCH_CUR: n_cur = ram_rdata;
            OP_WR_ALLOC: begin
                // mark used, shrink when a split follows
                ram_we    = 1'b1;
                ram_wdata = r_cur;
                ram_wdata.used = 1'b1;
                if (o_stat.split_ok) begin
                    ram_wdata.length = r_size;
                end
                n_dout = r_cur.offset + HDR16;
                n_sh   = r_count[IDX_W-1:0];
            end
            OP_SH_UP: begin
                // entry read at sh-1 last cycle moves up into sh
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_sh      = r_sh - 1'b1;
            end
            OP_WR_SPLIT: begin
                ram_we    = 1'b1;
                ram_wdata = '{offset: r_cur.offset + HDR16 + r_size,
                              length: rest - HDR16, used: 1'b0};
                n_count   = r_count + 1'b1;
            end
            OP_FREE_CUR: begin
                ram_we    = 1'b1;
                ram_wdata = r_cur;
                ram_wdata.used = 1'b0;
                n_cur.used = 1'b0;
            end
            OP_RD_NEXT, OP_RD_PREV: n_nbr = ram_rdata;
            OP_MERGE_NEXT: begin
                n_cur.length = r_cur.length + r_nbr.length + HDR16;
                ram_we    = 1'b1;
                ram_wdata = n_cur;
                n_sh      = r_idx + 1'b1;
                n_count   = r_count - 1'b1;
            end
            OP_SH_DOWN: begin
                // entry read at sh+1 last cycle moves down into sh
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_sh      = r_sh + 1'b1;
            end
            OP_MERGE_PREV: begin
                n_cur = r_nbr;
                n_cur.length = r_nbr.length + r_cur.length + HDR16;
                ram_we    = 1'b1;
                ram_wdata = n_cur;
                n_sh      = r_idx;
                n_idx     = r_idx - 1'b1;
                n_count   = r_count - 1'b1;
            end
            OP_STEP: n_idx = r_idx + 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(1);
            r_idx   <= '0;
            r_sh    <= '0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            r_sh    <= n_sh;
        end
        r_cur  <= n_cur;
        r_nbr  <= n_nbr;
        r_dout <= n_dout;
        if (i_cmd.op == OP_START) begin
            r_kind <= i_kind;
            r_size <= i_size;
            r_addr <= i_addr;
        end
    end

    logic hit_alloc, hit_free;
    assign hit_alloc = !r_cur.used && r_cur.length >= r_size && r_size != 16'd0;
    assign hit_free  = r_cur.used && (r_cur.offset + HDR16 == r_addr);

    assign o_stat.hit      = (r_kind == KIND_ALLOC) ? hit_alloc : hit_free;
    assign o_stat.split_ok = (rest > HDR16) && (r_count != CNT_W'(MAX_BLOCKS));
    assign o_stat.last     = ({1'b0, r_idx} == r_count - 1'b1);
    assign o_stat.nbr_free = !r_nbr.used;
    // shift up stops above the granted entry, shift down at the table end
    assign o_stat.sh_done  = (r_kind == KIND_ALLOC) ? (r_sh == r_idx + 1'b1)
                            : ({1'b0, r_sh} >= r_count);
    assign o_stat.idx      = r_idx;
    assign o_stat.sh_ptr   = r_sh;
    assign o_data_address  = r_dout;

`ifndef ASSERT_OFF
    a_count_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count out of range");
    a_init_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_INIT |=> r_count == CNT_W'(1))
        else $error("init did not reset count");
    a_split_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_WR_SPLIT |=> r_count == $past(r_count) + 1'b1)
        else $error("split did not grow table");
`endif
endmodule

FILE: rtl/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for scan, split and merge of the block table.
// ----------------------------------------------------------------------------
module ffba_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_init,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  logic            i_kind,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output logic [1:0]      o_status,
    output ffba_pkg::t_cmd  o_cmd,
    input  ffba_pkg::t_stat i_stat
);
    import ffba_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE    = 16'b0000000000000001,
        S_RD      = 16'b0000000000000010,
        S_LATCH   = 16'b0000000000000100,
        S_CHECK   = 16'b0000000000001000,
        S_SHUP_RD = 16'b0000000000010000,
        S_SHUP_WR = 16'b0000000000100000,
        S_SPLIT   = 16'b0000000001000000,
        S_RDN     = 16'b0000000010000000,
        S_LATN    = 16'b0000000100000000,
        S_MERGEN  = 16'b0000001000000000,
        S_SHDN_RD = 16'b0000010000000000,
        S_SHDN_WR = 16'b0000100000000000,
        S_RDP     = 16'b0001000000000000,
        S_LATP    = 16'b0010000000000000,
        S_MERGEP  = 16'b0100000000000000,
        S_DONE    = 16'b1000000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       r_prev, n_prev;     // the shift-down belongs to the previous merge

    assign o_req_ready = (r_state == S_IDLE) && !i_init;
    assign o_rsp_valid = (r_state == S_DONE);
    assign o_status    = r_status;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_prev   = r_prev;
        o_cmd    = '{op: OP_NONE, addr: i_stat.idx};
        case (r_state)
            S_IDLE: begin
                if (i_init) begin
                    o_cmd.op = OP_INIT;
                end else if (i_req_valid) begin
                    o_cmd.op = OP_START;
                    n_status = (i_kind == KIND_ALLOC) ? ST_FAILED : ST_NOTFOUND;
                    n_state  = S_RD;
                end
            end
            S_RD: begin
                o_cmd.op = OP_RD_CUR;
                n_state  = S_LATCH;
            end
            S_LATCH: begin
                o_cmd.op = OP_LATCH_CUR;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (!i_stat.hit) begin
                    if (i_stat.last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.op = OP_STEP;
                        n_state  = S_RD;
                    end
                end else if (r_status == ST_FAILED) begin
                    o_cmd.op = OP_WR_ALLOC;
                    n_status = ST_GRANTED;
                    n_state  = i_stat.split_ok ? S_SHUP_RD : S_DONE;
                end else begin
                    o_cmd.op = OP_FREE_CUR;
                    n_status = ST_FREED;
                    n_prev   = 1'b0;
                    n_state  = S_RDN;
                end
            end
            S_SHUP_RD: begin
                if (i_stat.sh_done) begin
                    n_state = S_SPLIT;
                end else begin
                    o_cmd = '{op: OP_RD_CUR, addr: i_stat.sh_ptr - 1'b1};
                    n_state = S_SHUP_WR;
                end
            end
            S_SHUP_WR: begin
                o_cmd = '{op: OP_SH_UP, addr: i_stat.sh_ptr};
                n_state = S_SHUP_RD;
            end
            S_SPLIT: begin
                o_cmd = '{op: OP_WR_SPLIT, addr: i_stat.idx + 1'b1};
                n_state = S_DONE;
            end
            S_RDN: begin
                // no next entry when the freed block is the last one
                if (i_stat.last) begin
                    n_state = S_RDP;
                end else begin
                    o_cmd = '{op: OP_RD_CUR, addr: i_stat.idx + 1'b1};
                    n_state = S_LATN;
                end
            end
            S_LATN: begin
                o_cmd = '{op: OP_RD_NEXT, addr: i_stat.idx + 1'b1};
                n_state = S_MERGEN;
            end
            S_MERGEN: begin
                n_state = S_RDP;
                if (i_stat.nbr_free) begin
                    o_cmd.op = OP_MERGE_NEXT;
                    n_state  = S_SHDN_RD;
                end
            end
            S_SHDN_RD: begin
                if (i_stat.sh_done) begin
                    n_state = r_prev ? S_DONE : S_RDP;
                end else begin
                    o_cmd = '{op: OP_RD_CUR, addr: i_stat.sh_ptr + 1'b1};
                    n_state = S_SHDN_WR;
                end
            end
            S_SHDN_WR: begin
                o_cmd = '{op: OP_SH_DOWN, addr: i_stat.sh_ptr};
                n_state = S_SHDN_RD;
            end
            S_RDP: begin
                if (i_stat.idx == '0) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd = '{op: OP_RD_CUR, addr: i_stat.idx - 1'b1};
                    n_state = S_LATP;
                end
            end
            S_LATP: begin
                o_cmd = '{op: OP_RD_PREV, addr: i_stat.idx - 1'b1};
                n_state = S_MERGEP;
            end
            S_MERGEP: begin
                n_state = S_DONE;
                if (i_stat.nbr_free) begin
                    o_cmd = '{op: OP_MERGE_PREV, addr: i_stat.idx - 1'b1};
                    n_prev  = 1'b1;
                    n_state = S_SHDN_RD;
                end
            end
            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_FAILED;
            r_prev   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_prev   <= n_prev;
        end
    end

`ifndef ASSERT_OFF
    a_rsp_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_status))
        else $error("response changed while stalled");
    a_no_init_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == OP_INIT |-> r_state == S_IDLE)
        else $error("init while busy");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
`endif
endmodule

FILE: rtl/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit allocator with coalescing over a byte arena.
// ----------------------------------------------------------------------------
// Requests arrive on a valid/ready channel (kind, request_size, block_address)
// and each one yields exactly one response (status, data_address).
// One request is worked on at a time. A scan over the block table in the
// single-port table RAM visits each entry in the states read, latch and
// check; a split shifts the later entries up and each merge shifts them
// down, each moved entry being read and then written. The table holds at
// most 64 blocks. The response is held until taken; no new request is
// accepted meanwhile. Register arena_bytes at APB address 0 (reset 4096);
// any write to it reinitializes the table to one free block. After reset
// the table is set up before the first request is accepted.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffba_req_if.sink    req,
    ffba_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffba_pkg::*;

    logic [15:0] r_arena;
    logic        r_init;
    logic        wr;
    t_cmd        cmd;
    t_stat       stat;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign prdata = (paddr == REG_ARENA) ? {16'd0, r_arena} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena <= ARENA_RESET;
            r_init  <= 1'b1;
        end else begin
            if (wr && paddr == REG_ARENA) begin
                r_arena <= pwdata[15:0];
                r_init  <= 1'b1;
            end else if (cmd.op == OP_INIT) begin
                r_init <= 1'b0;
            end
        end
    end

    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (r_init),
        .i_req_valid(req.valid),
        .o_req_ready(req.ready),
        .i_kind     (req.kind),
        .o_rsp_valid(rsp.valid),
        .i_rsp_ready(rsp.ready),
        .o_status   (rsp.status),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    ffba_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_kind        (req.kind),
        .i_size        (req.request_size),
        .i_addr        (req.block_address),
        .i_arena       (r_arena),
        .o_stat        (stat),
        .o_data_address(rsp.data_address)
    );
endmodule
